// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and sizes of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS);
  localparam int SLOT_FW   = 3;  // width of the slot field on the ports

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_EXIT = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  // per-slot task state
  localparam logic [1:0] TS_WAITING = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_ACTIVE  = 2'd2;

  // result status codes
  localparam logic [1:0] RS_OK       = 2'd0;
  localparam logic [1:0] RS_NO_READY = 2'd1;
  localparam logic [1:0] RS_DUP      = 2'd2;
  localparam logic [1:0] RS_EMPTY    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PRED,
    S_ADD_LINK1,
    S_ADD_LINK2,
    S_EX_START,
    S_EX_LINK,
    S_SW_START,
    S_SW_WALK,
    S_RESP
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;     // latch a new transaction
    logic       rd_p;        // read next pointer at walk pointer, else at current
    logic       p_load_cur;  // walk pointer <= current, count <= 0
    logic       p_load_nxt;  // walk pointer <= successor read, count <= 0
    logic       p_adv;       // walk pointer <= successor read, count++
    logic       set_state;   // mark slot ready or waiting
    logic       add_first;   // first task: self link, make current and active
    logic       link_pred;   // next[p] <= slot
    logic       link_slot;   // next[slot] <= current, slot joins the ring
    logic       ex_clear;    // unlink current: clear flags, keep its successor
    logic       ex_empty;    // last task left: ring empty
    logic       ex_link;     // next[p] <= saved successor, current <= p
    logic       demote;      // active current task drops to ready
    logic       activate;    // task at p becomes active and current
    logic       res_set;     // record result status
    logic [1:0] res_code;
    logic       load_out;    // load the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic slot_ok;
    logic slot_in_ring;
    logic nonempty;
    logic nxt_eq_cur;
    logic p_ready;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/rrts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer of the scheduler: decodes a command and steps the ring walks.
// ----------------------------------------------------------------------------
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = RS_OK;
        unique case (stat.op)
          OP_SET: begin
            cmd.set_state = stat.slot_ok;
            state_next    = S_RESP;
          end
          OP_ADD: begin
            if (!stat.slot_ok) begin
              state_next = S_RESP;
            end else if (stat.slot_in_ring) begin
              cmd.res_code = RS_DUP;
              state_next   = S_RESP;
            end else if (!stat.nonempty) begin
              cmd.add_first = 1'b1;
              state_next    = S_RESP;
            end else begin
              cmd.p_load_cur = 1'b1;
              state_next     = S_PRED;
            end
          end
          OP_TICK: begin
            if (!stat.nonempty) begin
              cmd.res_code = RS_EMPTY;
              state_next   = S_RESP;
            end else begin
              state_next = S_SW_START;
            end
          end
          OP_EXIT: begin
            if (!stat.nonempty) begin
              cmd.res_code = RS_EMPTY;
              state_next   = S_RESP;
            end else begin
              state_next = S_EX_START;
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_PRED: begin
        // find the slot whose successor is the current task
        cmd.rd_p = 1'b1;
        if (stat.nxt_eq_cur || stat.cnt_last) begin
          cmd.p_load_cur = !stat.nxt_eq_cur;
          state_next     = (stat.op == OP_ADD) ? S_ADD_LINK1 : S_EX_LINK;
        end else begin
          cmd.p_adv = 1'b1;
        end
      end
      S_ADD_LINK1: begin
        cmd.link_pred = 1'b1;
        state_next    = S_ADD_LINK2;
      end
      S_ADD_LINK2: begin
        cmd.link_slot = 1'b1;
        state_next    = S_RESP;
      end
      S_EX_START: begin
        cmd.ex_clear = 1'b1;
        if (stat.nxt_eq_cur) begin
          cmd.ex_empty = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = RS_EMPTY;
          state_next   = S_RESP;
        end else begin
          cmd.p_load_cur = 1'b1;
          state_next     = S_PRED;
        end
      end
      S_EX_LINK: begin
        cmd.ex_link = 1'b1;
        state_next  = S_SW_START;
      end
      S_SW_START: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = RS_OK;
        if (stat.nxt_eq_cur) begin
          state_next = S_RESP;
        end else begin
          cmd.demote     = 1'b1;
          cmd.p_load_nxt = 1'b1;
          state_next     = S_SW_WALK;
        end
      end
      S_SW_WALK: begin
        cmd.rd_p = 1'b1;
        if (stat.p_ready) begin
          cmd.activate = 1'b1;
          state_next   = S_RESP;
        end else if (stat.cnt_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = RS_NO_READY;
          state_next   = S_RESP;
        end else begin
          cmd.p_adv = 1'b1;
        end
      end
      S_RESP: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/rrts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: next-pointer table, task states, walk pointer, output.
// ----------------------------------------------------------------------------
module rrts_dp
  import rrts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [1:0]         in_operation,
  input  logic [SLOT_FW-1:0] in_task_slot,
  input  logic               in_task_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_FW-1:0] out_current_task,
  output logic               out_any_task,
  output logic               out_switched,
  output logic [1:0]         out_status
);

  logic [SLOT_W-1:0]  nxt_mem [MAX_TASKS];
  logic [1:0]         task_status [MAX_TASKS];
  logic [MAX_TASKS-1:0] in_ring;
  logic [SLOT_W-1:0]  cur;
  logic               nonempty;

  op_t                op;
  logic [SLOT_FW-1:0] slot;
  logic               rdy;
  logic [SLOT_W-1:0]  start_slot;
  logic               force_sw;
  logic [1:0]         res_code;

  logic [SLOT_W-1:0]  p;
  logic [CNT_W-1:0]   cnt;
  logic [SLOT_W-1:0]  succ_c;

  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  nxt_rd;
  logic [SLOT_W-1:0]  slot_idx;

  assign slot_idx = slot[SLOT_W-1:0];
  assign rd_addr  = cmd.rd_p ? p : cur;
  assign nxt_rd   = nxt_mem[rd_addr];

  always_comb begin
    stat.op           = op;
    stat.slot_ok      = (32'(slot) < MAX_TASKS);
    stat.slot_in_ring = in_ring[slot_idx];
    stat.nonempty     = nonempty;
    stat.nxt_eq_cur   = (nxt_rd == cur);
    stat.p_ready      = (task_status[p] == TS_READY);
    stat.cnt_last     = (cnt == CNT_W'(MAX_TASKS - 1));
    stat.out_free     = !out_valid || out_ready;
  end

  // transaction latch and per-item bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= op_t'(in_operation);
      slot       <= in_task_slot;
      rdy        <= in_task_ready;
      start_slot <= cur;
    end
    if (cmd.res_set) begin
      res_code <= cmd.res_code;
    end
    if (cmd.ex_clear) begin
      succ_c <= nxt_rd;
    end
    if (cmd.p_load_cur) begin
      p   <= cur;
      cnt <= '0;
    end else if (cmd.p_load_nxt) begin
      p   <= nxt_rd;
      cnt <= '0;
    end else if (cmd.p_adv) begin
      p   <= nxt_rd;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_sw <= 1'b0;
    end else if (cmd.capture) begin
      force_sw <= 1'b0;
    end else if (cmd.add_first || cmd.ex_clear) begin
      force_sw <= 1'b1;
    end
  end

  // next-pointer table, no reset: only linked entries are ever read
  always_ff @(posedge clk) begin
    if (cmd.add_first) begin
      nxt_mem[slot_idx] <= slot_idx;
    end else if (cmd.link_pred) begin
      nxt_mem[p] <= slot_idx;
    end else if (cmd.link_slot) begin
      nxt_mem[slot_idx] <= cur;
    end else if (cmd.ex_link) begin
      nxt_mem[p] <= succ_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_status[i] <= TS_WAITING;
      end
      in_ring  <= '0;
      cur      <= '0;
      nonempty <= 1'b0;
    end else begin
      if (cmd.set_state) begin
        task_status[slot_idx] <= rdy ? TS_READY : TS_WAITING;
      end else if (cmd.add_first) begin
        task_status[slot_idx] <= TS_ACTIVE;
        in_ring[slot_idx]     <= 1'b1;
        cur                   <= slot_idx;
        nonempty              <= 1'b1;
      end else if (cmd.link_slot) begin
        in_ring[slot_idx] <= 1'b1;
      end else if (cmd.ex_clear) begin
        task_status[cur] <= TS_WAITING;
        in_ring[cur]     <= 1'b0;
        if (cmd.ex_empty) begin
          nonempty <= 1'b0;
          cur      <= '0;
        end
      end else if (cmd.ex_link) begin
        cur <= p;
      end else if (cmd.demote) begin
        if (task_status[cur] == TS_ACTIVE) begin
          task_status[cur] <= TS_READY;
        end
      end else if (cmd.activate) begin
        task_status[p] <= TS_ACTIVE;
        cur            <= p;
      end
    end
  end

  // output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_current_task <= nonempty ? SLOT_FW'(cur) : '0;
      out_any_task     <= nonempty;
      out_switched     <= force_sw || (cur != start_slot);
      out_status       <= res_code;
    end
  end

endmodule

// ===== rtl/round_robin_task_scheduler_unit.sv =====
`timescale 1ns / 1ps
// The ring walks step one next pointer per cycle through the single table read
// port. One transaction is in work at a time; the next is accepted once its
// result sits in the output register. Synchronous reset empties the ring,
// marks all tasks waiting and clears the output valid; the pointer table is
// not reset.
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Round-robin scheduler over a ring of task slots with add, tick, exit and
// set-state commands.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit
  import rrts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [2:0] task_slot, [3] task_ready, [7:4] zero
  input  logic [1:0] s_tuser,   // [1:0] operation
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [2:0] current_task, [3] any_task,
                                // [4] switched, [6:5] status, [7] zero
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [SLOT_FW-1:0] current_task;
  logic               any_task;
  logic               switched;
  logic [1:0]         status;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (s_tuser),
    .in_task_slot     (s_tdata[2:0]),
    .in_task_ready    (s_tdata[3]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_current_task (current_task),
    .out_any_task     (any_task),
    .out_switched     (switched),
    .out_status       (status)
  );

  assign m_tdata = {1'b0, status, switched, any_task, current_task};

endmodule

// ===== rtl/rrts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker
  import rrts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_empty_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> m_tdata[2:0] == '0)
    else $error("empty ring reports a nonzero current task");

  a_dup_no_switch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:5] == RS_DUP |-> !m_tdata[4])
    else $error("rejected add switched tasks");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:5] == RS_EMPTY |-> !m_tdata[3])
    else $error("ring-empty status with tasks present");

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
